// ===== rtl/sd_spi_command_engine_assert.svh =====
// Assertion macros shared by the command engine RTL.
`ifndef SD_SPI_COMMAND_ENGINE_ASSERT_SVH
`define SD_SPI_COMMAND_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define SDC_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdc: same-cycle check failed");

`define SDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdc: next-cycle check failed");

`else

`define SDC_ASSERT_IMPLIES(lbl, ante, cons)

`define SDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/sdc_pkg.sv =====
// Types, codes and constants of the SD card SPI command engine.
package sdc_pkg;

	localparam int BUSY_POLLS_DEF  = 255;
	localparam int BUSY_ROUNDS_DEF = 4;
	localparam int REPLY_POLLS_DEF = 8;

	localparam logic [7:0] TOK_RESET  = 8'h40;
	localparam logic [7:0] TOK_IFCOND = 8'h48;
	localparam logic [7:0] TOK_STOP   = 8'h4C;
	localparam logic [7:0] CRC_RESET  = 8'h95;
	localparam logic [7:0] CRC_IFCOND = 8'h87;
	localparam logic [7:0] FILL_BYTE  = 8'hFF;

	localparam logic [2:0] FRAME_LEN      = 3'd6;
	localparam logic [2:0] FRAME_LEN_STOP = 3'd7;

	typedef enum logic {
		OP_START = 1'b0,
		OP_REPLY = 1'b1
	} op_t;

	typedef enum logic {
		KIND_XFER = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_NOCARD  = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_BUSY  = 4'b0010,
		PH_SEND  = 4'b0100,
		PH_REPLY = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       done;
	} frame_t;

endpackage

// ===== rtl/sdc_frame.sv =====
// Command frame byte selection: token, argument bytes, CRC and trailing fill.
module sdc_frame (
	input  logic [7:0]      command,
	input  logic [31:0]     arg,
	input  logic [2:0]      index,
	output sdc_pkg::frame_t frame
);
	import sdc_pkg::*;

	logic [2:0] len;

	always_comb begin
		len = (command == TOK_STOP) ? FRAME_LEN_STOP : FRAME_LEN;
		frame.done = (index >= len);
		unique case (index)
			3'd0: frame.data = command;
			3'd1: frame.data = arg[31:24];
			3'd2: frame.data = arg[23:16];
			3'd3: frame.data = arg[15:8];
			3'd4: frame.data = arg[7:0];
			3'd5: begin
				priority if (command == TOK_RESET) begin
					frame.data = CRC_RESET;
				end else if (command == TOK_IFCOND) begin
					frame.data = CRC_IFCOND;
				end else begin
					frame.data = FILL_BYTE;
				end
			end
			default: frame.data = FILL_BYTE;
		endcase
	end

endmodule

// ===== rtl/sd_spi_command_engine.sv =====
// SD card SPI-mode command engine: input register, sequencer step, result register.
// An accepted beat is registered in the input register, then the sequencer step runs and
// its result beat is written to the result register. One beat per cycle is sustained while
// the result is not stalled. A stalled result holds both registers.
// Asynchronous reset returns the engine to idle with counters, held command and argument
// cleared and both pipeline registers empty. A reply beat while idle yields no result.
`include "sd_spi_command_engine_assert.svh"

module sd_spi_command_engine #(
	parameter int BUSY_POLLS  = sdc_pkg::BUSY_POLLS_DEF,
	parameter int BUSY_ROUNDS = sdc_pkg::BUSY_ROUNDS_DEF,
	parameter int REPLY_POLLS = sdc_pkg::REPLY_POLLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        operation,
	input  logic [7:0]  command_byte,
	input  logic [31:0] argument,
	input  logic [7:0]  reply_byte,
	input  logic        card_present,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [7:0]  send_byte,
	output logic [1:0]  status,
	output logic [7:0]  response
);
	import sdc_pkg::*;

	localparam int POLL_MAX = (BUSY_POLLS > REPLY_POLLS) ? BUSY_POLLS : REPLY_POLLS;
	localparam int PCW      = $clog2(POLL_MAX + 1);
	localparam int RW       = (BUSY_ROUNDS > 1) ? $clog2(BUSY_ROUNDS) : 1;

	logic        valid_s1;
	op_t         op_s1;
	logic [7:0]  cmd_s1;
	logic [31:0] arg_s1;
	logic [7:0]  reply_s1;
	logic        present_s1;

	phase_t      phase_q, phase_d;
	logic [RW-1:0]  round_q, round_d;
	logic [PCW-1:0] poll_q, poll_d, poll_inc;
	logic [2:0]  index_q, index_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [31:0] arg_q, arg_d;

	logic        res_valid_q;
	kind_t       res_kind_q;
	logic [7:0]  res_byte_q;
	status_t     res_status_q;
	logic [7:0]  res_resp_q;

	logic        emit;
	kind_t       res_kind;
	logic [7:0]  res_byte;
	status_t     res_status;
	logic [7:0]  res_resp;

	logic        advance, load_s1, fire_s1;
	logic        busy_hit, last_round;
	frame_t      frame;

	sdc_frame u_frame (
		.command (cmd_q),
		.arg     (arg_q),
		.index   (index_q),
		.frame   (frame)
	);

	assign advance    = !res_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign load_s1    = item_valid && !item_stall;
	assign fire_s1    = valid_s1 && advance;

	assign poll_inc   = poll_q + PCW'(1);
	assign busy_hit   = (poll_inc >= PCW'(BUSY_POLLS));
	assign last_round = (round_q == RW'(BUSY_ROUNDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1      <= op_t'(operation);
			cmd_s1     <= command_byte;
			arg_s1     <= argument;
			reply_s1   <= reply_byte;
			present_s1 <= card_present;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		round_d    = round_q;
		poll_d     = poll_q;
		index_d    = index_q;
		cmd_d      = cmd_q;
		arg_d      = arg_q;
		emit       = 1'b0;
		res_kind   = KIND_XFER;
		res_byte   = FILL_BYTE;
		res_status = ST_OK;
		res_resp   = 8'h00;
		if (op_s1 == OP_START) begin
			cmd_d   = cmd_s1;
			arg_d   = arg_s1;
			round_d = '0;
			poll_d  = '0;
			index_d = 3'd0;
			emit    = 1'b1;
			priority if (!present_s1) begin
				phase_d    = PH_IDLE;
				res_kind   = KIND_DONE;
				res_status = ST_NOCARD;
			end else if (cmd_s1 == TOK_STOP) begin
				phase_d  = PH_SEND;
				res_byte = cmd_s1;
				index_d  = 3'd1;
			end else begin
				phase_d = PH_BUSY;
			end
		end else begin
			unique case (phase_q)
				PH_BUSY: begin
					emit = 1'b1;
					if (reply_s1 != FILL_BYTE) begin
						poll_d = poll_inc;
					end
					if ((reply_s1 == FILL_BYTE || busy_hit) && last_round) begin
						priority if (reply_s1 != FILL_BYTE) begin
							phase_d    = PH_IDLE;
							res_kind   = KIND_DONE;
							res_status = ST_BUSY;
						end else if (!present_s1) begin
							phase_d    = PH_IDLE;
							res_kind   = KIND_DONE;
							res_status = ST_NOCARD;
						end else begin
							phase_d  = PH_SEND;
							res_byte = cmd_q;
							index_d  = 3'd1;
						end
					end else begin
						if (reply_s1 == FILL_BYTE || busy_hit) begin
							round_d = round_q + RW'(1);
							poll_d  = '0;
						end
						if (!present_s1) begin
							phase_d    = PH_IDLE;
							res_kind   = KIND_DONE;
							res_status = ST_NOCARD;
						end
					end
				end
				PH_SEND: begin
					emit = 1'b1;
					priority if (!frame.done) begin
						res_byte = frame.data;
						index_d  = index_q + 3'd1;
					end else if (!present_s1) begin
						phase_d    = PH_IDLE;
						res_kind   = KIND_DONE;
						res_status = ST_NOCARD;
					end else begin
						phase_d = PH_REPLY;
						poll_d  = '0;
					end
				end
				PH_REPLY: begin
					emit   = 1'b1;
					poll_d = poll_inc;
					priority if (!reply_s1[7]) begin
						phase_d    = PH_IDLE;
						res_kind   = KIND_DONE;
						res_status = ST_OK;
						res_resp   = reply_s1;
					end else if (poll_inc >= PCW'(REPLY_POLLS)) begin
						phase_d    = PH_IDLE;
						res_kind   = KIND_DONE;
						res_status = ST_TIMEOUT;
					end else if (!present_s1) begin
						phase_d    = PH_IDLE;
						res_kind   = KIND_DONE;
						res_status = ST_NOCARD;
					end else begin
						phase_d = PH_REPLY;
					end
				end
				default: emit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			round_q <= '0;
			poll_q  <= '0;
			index_q <= 3'd0;
			cmd_q   <= 8'h00;
			arg_q   <= 32'h0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			round_q <= round_d;
			poll_q  <= poll_d;
			index_q <= index_d;
			cmd_q   <= cmd_d;
			arg_q   <= arg_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			res_kind_q   <= res_kind;
			res_byte_q   <= res_byte;
			res_status_q <= res_status;
			res_resp_q   <= res_resp;
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = res_kind_q;
	assign send_byte    = res_byte_q;
	assign status       = res_status_q;
	assign response     = res_resp_q;

	`SDC_ASSERT_IMPLIES(a_done_fill, result_valid && kind == KIND_DONE, send_byte == FILL_BYTE)
	`SDC_ASSERT_IMPLIES(a_xfer_clean, result_valid && kind == KIND_XFER,
		status == ST_OK && response == 8'h00)
	`SDC_ASSERT_IMPLIES(a_ok_r1, result_valid && kind == KIND_DONE && status == ST_OK, !response[7])
	`SDC_ASSERT_NEXT(a_done_idle, fire_s1 && emit && res_kind == KIND_DONE, phase_q == PH_IDLE)
	`SDC_ASSERT_IMPLIES(a_idle_quiet, fire_s1 && op_s1 == OP_REPLY && phase_q == PH_IDLE, !emit)

endmodule
